/* hw/rtl/eabp_pkg.sv */
`default_nettype none

package eabp_pkg;

  localparam int WINDOW_LEN = 256;
  localparam int WIN_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  localparam int COEF_DEPTH = 18;
  localparam int COEF_AW = 5;
  localparam int HIST_DEPTH = 16;
  localparam int HIST_AW = 4;

  localparam logic [COEF_AW-1:0] NUM_COEF = 5'd18;
  localparam logic [COEF_AW-1:0] HP_BASE = 5'd0;
  localparam logic [COEF_AW-1:0] LP_BASE = 5'd9;
  localparam logic [COEF_AW-1:0] CLR_LAST = 5'd17;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  localparam logic [25:0] UV_PER_CODE = 26'd52800;
  localparam logic [25:0] UV_OFFSET = 26'd27033600;

  typedef struct packed {
    logic              func;
    logic [9:0]        adc_code;
    logic [4:0]        coef_index;
    logic signed [31:0] coef_value;
  } sample_t;

  typedef struct packed {
    logic signed [25:0] raw_microvolts;
    logic signed [31:0] filtered_sample;
    logic               window_end;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/eabp_ram.sv */
`default_nettype none

module eabp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/eeg_adc_bandpass_iir_chain.sv */
// samples are taken only while idle and processed one at a time, each stepping
// through nine taps per filter stage on the single 32x32 multiplier
// a coefficient load request gives no result
// a result waiting at the output does not hold off the next request
// after reset a clearing pass zeroes coefficients and history, stall held high
`default_nettype none

module eeg_adc_bandpass_iir_chain
  import eabp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sample_valid,
  output logic         sample_stall,
  input  wire sample_t sample,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_WRY   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]          state;
  logic [COEF_AW-1:0]  clr_cnt;
  logic [3:0]          cnt;
  logic                filt;
  logic [1:0]          ptr;
  logic [WIN_W-1:0]    wpos;
  logic signed [25:0]  raw;
  logic signed [31:0]  x_cur;
  logic signed [67:0]  acc;
  logic signed [63:0]  prod;
  logic                s1_valid;
  logic                s1_neg;
  logic                s1_usex;
  logic                s2_valid;
  logic                s2_neg;

  logic                accept;
  logic                issue;
  logic                out_free;
  logic [25:0]         code_uv;
  logic signed [25:0]  raw_conv;
  logic [1:0]          ptr_new;

  logic                coef_we;
  logic [COEF_AW-1:0]  coef_waddr;
  logic [31:0]         coef_wdata;
  logic [COEF_AW-1:0]  coef_raddr;
  logic [31:0]         coef_rdata;

  logic                hist_we;
  logic [HIST_AW-1:0]  hist_waddr;
  logic [31:0]         hist_wdata;
  logic [HIST_AW-1:0]  hist_raddr;
  logic [31:0]         hist_rdata;

  logic signed [31:0]  mul_b;
  logic signed [67:0]  prod_ext;
  logic signed [67:0]  acc_rnd;
  logic signed [40:0]  y_wide;
  logic signed [31:0]  y_sat;

  assign sample_stall = (state != ST_IDLE);
  assign accept = sample_valid && !sample_stall;
  assign issue = (state == ST_MAC) && (cnt <= 4'd8);
  assign out_free = !result_valid || !result_stall;
  assign ptr_new = ptr + 2'd1;

  assign code_uv = 26'(sample.adc_code) * UV_PER_CODE;
  assign raw_conv = signed'(code_uv - UV_OFFSET);

  // rounding to nearest, ties up, then saturation to 32 bits
  assign acc_rnd = acc + (68'sd1 <<< 26);
  assign y_wide = acc_rnd[67:27];
  assign y_sat = (y_wide[40:31] == {10{y_wide[31]}}) ? y_wide[31:0] :
                 (y_wide[40] ? 32'sh8000_0000 : 32'sh7fff_ffff);

  assign coef_raddr = (filt ? LP_BASE : HP_BASE) + {1'b0, cnt};
  // ages of x and y taps share the same slot arithmetic on a circular history
  assign hist_raddr = {filt, (cnt >= 4'd5), 2'(ptr - cnt[1:0] + 2'd1)};

  always_comb begin
    coef_we = 1'b0;
    coef_waddr = clr_cnt;
    coef_wdata = '0;
    if (state == ST_CLEAR) begin
      coef_we = 1'b1;
    end else if (accept && (sample.func == FUNC_LOAD) && (sample.coef_index < NUM_COEF)) begin
      coef_we = 1'b1;
      coef_waddr = sample.coef_index;
      coef_wdata = sample.coef_value;
    end
  end

  always_comb begin
    hist_we = 1'b0;
    hist_waddr = clr_cnt[HIST_AW-1:0];
    hist_wdata = '0;
    case (state)
      ST_CLEAR: begin
        hist_we = 1'b1;
      end
      ST_MAC: begin
        // oldest input slot was read at tap four, so it may be replaced now
        if (cnt == 4'd5) begin
          hist_we = 1'b1;
          hist_waddr = {filt, 1'b0, ptr_new};
          hist_wdata = x_cur;
        end
      end
      ST_WRY: begin
        hist_we = 1'b1;
        hist_waddr = {filt, 1'b1, ptr_new};
        hist_wdata = y_sat;
      end
      default: begin
        hist_we = 1'b0;
      end
    endcase
  end

  eabp_ram #(
    .WIDTH(32),
    .DEPTH(COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  eabp_ram #(
    .WIDTH(32),
    .DEPTH(HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  assign mul_b = s1_usex ? x_cur : signed'(hist_rdata);
  assign prod_ext = {{4{prod[63]}}, prod};

  always_ff @(posedge clk) begin
    prod <= signed'(coef_rdata) * mul_b;
    if (state == ST_IDLE || state == ST_WRY) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= s2_neg ? (acc - prod_ext) : (acc + prod_ext);
    end
    s1_neg <= (cnt >= 4'd5);
    s1_usex <= (cnt == 4'd0);
    s2_neg <= s1_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      cnt <= '0;
      filt <= 1'b0;
      ptr <= '0;
      wpos <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      if ((state == ST_OUT) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 5'd1;
          if (clr_cnt == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (sample.func == FUNC_SAMPLE)) begin
            raw <= raw_conv;
            x_cur <= 32'(raw_conv);
            filt <= 1'b0;
            cnt <= '0;
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd10) begin
            state <= ST_WRY;
          end
        end
        ST_WRY: begin
          x_cur <= y_sat;
          cnt <= '0;
          if (!filt) begin
            filt <= 1'b1;
            state <= ST_MAC;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            result.raw_microvolts <= raw;
            result.filtered_sample <= x_cur;
            result.window_end <= (wpos == WIN_W'(WINDOW_LEN - 1));
            wpos <= (wpos == WIN_W'(WINDOW_LEN - 1)) ? '0 : wpos + 1'b1;
            ptr <= ptr_new;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_OUT)
    else $error("result raised outside the output step");

  a_acc_only_in_mac: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> state == ST_MAC)
    else $error("product arrived outside the tap sequence");

  a_wry_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRY |-> !s1_valid && !s2_valid)
    else $error("output written back before all taps were summed");

  a_out_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free) |=> result_valid && state == ST_IDLE)
    else $error("finished sample not delivered");

endmodule

`default_nettype wire

/* tb/eabp_checker.sv */
`timescale 1ns / 100ps

module eabp_checker
  import eabp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  input  logic    sample_stall,
  input  sample_t sample,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      fail_count,
  output int      pending
);

  localparam int MAX_REPORTS = 10;

  logic signed [31:0] coefs [COEF_DEPTH];
  // stage 0 is the high-pass, stage 1 the low-pass; entry 0 is the newest
  logic signed [31:0] past_in [2][4];
  logic signed [31:0] past_out [2][4];
  int                 window_count;
  result_t            due_results [$];
  int                 fails;

  function automatic logic signed [31:0] iir_stage(input logic signed [31:0] x,
                                                  input int stage);
    int                 b_base;
    int                 a_base;
    longint             prod;
    logic signed [67:0] acc;
    logic signed [67:0] rounded;
    logic signed [31:0] y;
    b_base = (stage == 0) ? 0 : 9;
    a_base = b_base + 5;
    prod = longint'(coefs[b_base]) * longint'(x);
    acc = {{4{prod[63]}}, prod};
    for (int i = 0; i < 4; i++) begin
      prod = longint'(coefs[b_base + 1 + i]) * longint'(past_in[stage][i]);
      acc = acc + {{4{prod[63]}}, prod};
      prod = longint'(coefs[a_base + i]) * longint'(past_out[stage][i]);
      acc = acc - {{4{prod[63]}}, prod};
    end
    // round half up, then clamp to 32 bits
    rounded = (acc + (68'sd1 <<< 26)) >>> 27;
    if (rounded > 68'sd2147483647) begin
      y = 32'sh7FFF_FFFF;
    end else if (rounded < -68'sd2147483648) begin
      y = 32'sh8000_0000;
    end else begin
      y = rounded[31:0];
    end
    for (int i = 3; i > 0; i--) begin
      past_in[stage][i] = past_in[stage][i-1];
      past_out[stage][i] = past_out[stage][i-1];
    end
    past_in[stage][0] = x;
    past_out[stage][0] = y;
    return y;
  endfunction

  function automatic result_t filter_sample(input logic [9:0] code);
    result_t            res;
    logic signed [31:0] microvolts;
    logic signed [31:0] hp_out;
    microvolts = $signed({22'd0, code}) * 32'sd52800 - 32'sd27033600;
    hp_out = iir_stage(microvolts, 0);
    res.raw_microvolts = microvolts[25:0];
    res.filtered_sample = iir_stage(hp_out, 1);
    window_count++;
    res.window_end = 1'b0;
    if (window_count >= WINDOW_LEN) begin
      window_count = 0;
      res.window_end = 1'b1;
    end
    return res;
  endfunction

  task automatic note_failure(input string what, input result_t want, input result_t got);
    fails++;
    if (fails <= MAX_REPORTS) begin
      $display("%0t: %s: expected raw %0d filtered %0d end %0b, got raw %0d filtered %0d end %0b",
               $realtime, what, want.raw_microvolts, want.filtered_sample, want.window_end,
               got.raw_microvolts, got.filtered_sample, got.window_end);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < COEF_DEPTH; i++) coefs[i] = '0;
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < 4; i++) begin
          past_in[s][i] = '0;
          past_out[s][i] = '0;
        end
      end
      window_count = 0;
      due_results.delete();
      fails = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          note_failure("unexpected result", '0, result);
        end else begin
          want = due_results.pop_front();
          if (want.raw_microvolts !== result.raw_microvolts ||
              want.filtered_sample !== result.filtered_sample ||
              want.window_end !== result.window_end) begin
            note_failure("result mismatch", want, result);
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        if (sample.func == FUNC_LOAD) begin
          if (sample.coef_index < NUM_COEF) coefs[sample.coef_index] = sample.coef_value;
        end else begin
          due_results.push_back(filter_sample(sample.adc_code));
        end
      end
    end
    fail_count <= fails;
    pending <= due_results.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import eabp_pkg::*;

  localparam int STUCK_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS = 342;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  sample_t sample = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_tickets = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stuck_cycles = 0;

  always #2 clk = ~clk;

  eeg_adc_bandpass_iir_chain DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  eabp_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_tickets) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_request(input sample_t req);
    sample <= req;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic put_sample(input logic [9:0] code);
    sample_t req;
    req.func = FUNC_SAMPLE;
    req.adc_code = code;
    req.coef_index = 5'($urandom);
    req.coef_value = $urandom;
    send_request(req);
  endtask

  task automatic put_load(input logic [4:0] idx, input logic signed [31:0] value);
    sample_t req;
    req.func = FUNC_LOAD;
    req.adc_code = 10'($urandom);
    req.coef_index = idx;
    req.coef_value = value;
    send_request(req);
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_code();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 10'd0;
    if (roll < 20) return 10'd1023;
    return 10'($urandom_range(1023));
  endfunction

  function automatic logic signed [31:0] pick_coef(input int idx);
    // feedback taps kept small so the sum of their magnitudes stays at most a half
    if ((idx >= 5 && idx <= 8) || idx >= 14) begin
      return int'($urandom_range(1 << 25)) - (1 << 24);
    end
    return int'($urandom_range(1 << 28)) - (1 << 27);
  endfunction

  task automatic random_stretch(inout int count);
    int         n;
    logic [4:0] idx;
    if ($urandom_range(99) < 80) begin
      for (int i = 0; i < COEF_DEPTH; i++) begin
        if (i == 0 || $urandom_range(99) < 70) begin
          put_load(5'(i), pick_coef(i));
          count++;
        end
      end
      n = $urandom_range(10, 60);
      for (int i = 0; i < n; i++) begin
        put_sample(pick_code());
        count++;
      end
    end else begin
      n = $urandom_range(3, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(1) == 0) begin
          idx = 5'($urandom);
          put_load(idx, $urandom);
          if (idx < NUM_COEF) count++;
        end else begin
          put_sample(10'($urandom));
          count++;
        end
      end
    end
  endtask

  task automatic random_phase(input int items);
    int count;
    count = 0;
    while (count < items) random_stretch(count);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero table, code extremes
    put_sample(10'd0);
    put_sample(10'd1023);
    // largest gain, ignored loads past the table end
    put_load(5'd0, 32'sh7FFF_FFFF);
    put_load(5'd31, 32'sh8000_0000);
    put_load(5'd18, 32'sd12345);
    put_sample(10'd1023);
    put_sample(10'd0);
    // most negative feedback tap, unity low-pass
    put_load(5'd5, 32'sh8000_0000);
    put_load(5'd9, 32'sd134217728);
    put_sample(10'd1023);
    put_sample(10'd0);
    put_sample(10'd511);
    // unity high-pass, then both last taps
    put_load(5'd0, 32'sd134217728);
    put_load(5'd5, 32'sd0);
    put_load(5'd4, -32'sd67108864);
    put_load(5'd8, 32'sd16777216);
    put_load(5'd13, 32'sh7FFF_FFFF);
    put_load(5'd14, -32'sd67108864);
    put_load(5'd17, 32'sh8000_0000);
    put_sample(10'd1023);
    put_sample(10'd1023);
    put_sample(10'd0);
    put_sample(10'd512);
    put_sample(10'd1);
    wait_drained();

    send_idle_pct = 13;
    recv_idle_pct <= 73;
    random_phase(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 73;
    recv_idle_pct <= 13;
    random_phase(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    for (int i = 0; i < COEF_DEPTH; i++) put_load(5'(i), pick_coef(i));
    // results held back while samples keep coming
    hold_tickets <= hold_tickets + 1;
    for (int i = 0; i < 40; i++) put_sample(pick_code());
    random_phase(PHASE_ITEMS - 58);
    wait_drained();

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      if (pending != 0) $display("%0d results never arrived", pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/eabp_pkg.sv
hw/rtl/eabp_ram.sv
hw/rtl/eeg_adc_bandpass_iir_chain.sv
tb/eabp_checker.sv
tb/tb.sv
